FILE: hdl/pld_pkg.sv
package pld_pkg;

  localparam int CoordW = 16;
  localparam int AbW = CoordW + 1;
  localparam int CW = 2 * CoordW + 1;
  localparam int ProdW = AbW + CoordW;
  localparam int SqW = 2 * AbW;
  localparam int NumW = CW + 2;
  localparam int NW = NumW - 1;
  localparam int SW = 2 * CoordW + 1;
  localparam int NLo = NW / 2;
  localparam int NHi = NW - NLo;
  localparam int PpW = NHi + NLo;
  localparam int NNW = 2 * NW;
  localparam int QW = 36;
  localparam int RootW = QW / 2;
  localparam int RemW = RootW + 3;
  localparam int DistW = 17;
  localparam logic [DistW-1:0] DistMax = {DistW{1'b1}};
  localparam int FrontStages = 5;
  localparam int Latency = FrontStages + 1 + QW + RootW + 1;

  typedef struct packed {
    logic signed [AbW-1:0] a;
    logic signed [AbW-1:0] b;
    logic signed [CW-1:0] c;
    logic degen;
  } side_t;

endpackage

FILE: hdl/pld_front.sv
module pld_front (
  input  logic clk,
  input  logic rst,
  input  logic in_v,
  input  logic signed [pld_pkg::CoordW-1:0] x1,
  input  logic signed [pld_pkg::CoordW-1:0] y1,
  input  logic signed [pld_pkg::CoordW-1:0] x2,
  input  logic signed [pld_pkg::CoordW-1:0] y2,
  input  logic signed [pld_pkg::CoordW-1:0] px,
  input  logic signed [pld_pkg::CoordW-1:0] py,
  output logic out_v,
  output pld_pkg::side_t out_side,
  output logic [pld_pkg::NNW-1:0] out_nn,
  output logic [pld_pkg::SW-1:0] out_s
);

  // Stage 1: coefficients a, b and the two products of c.
  logic v1, degen1;
  logic signed [pld_pkg::AbW-1:0] a1, b1;
  logic signed [2*pld_pkg::CoordW-1:0] p1, p2;
  logic signed [pld_pkg::CoordW-1:0] px1, py1;

  // Stage 2: c and all first-level products.
  logic v2;
  pld_pkg::side_t side2;
  logic signed [pld_pkg::ProdW-1:0] apx2, bpy2;
  logic signed [pld_pkg::SqW-1:0] aa2, bb2;

  // Stage 3: magnitude of the numerator and the squared norm.
  logic v3;
  pld_pkg::side_t side3;
  logic [pld_pkg::NW-1:0] n3;
  logic [pld_pkg::SW-1:0] s3;
  logic signed [pld_pkg::NumW-1:0] num;
  logic [pld_pkg::SqW-1:0] ssum;

  // Stage 4: partial products of n squared.
  logic v4;
  pld_pkg::side_t side4;
  logic [pld_pkg::SW-1:0] s4;
  logic [pld_pkg::PpW-1:0] hh4, hl4, ll4;

  assign num = pld_pkg::NumW'(apx2) + pld_pkg::NumW'(bpy2) + pld_pkg::NumW'(side2.c);
  assign ssum = $unsigned(aa2) + $unsigned(bb2);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      out_v <= 1'b0;
    end else begin
      v1 <= in_v;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      out_v <= v4;
    end
  end

  always_ff @(posedge clk) begin
    a1 <= pld_pkg::AbW'(y2) - pld_pkg::AbW'(y1);
    b1 <= pld_pkg::AbW'(x1) - pld_pkg::AbW'(x2);
    p1 <= x2 * y1;
    p2 <= x1 * y2;
    px1 <= px;
    py1 <= py;
    degen1 <= (x1 == x2) && (y1 == y2);

    side2.a <= a1;
    side2.b <= b1;
    side2.c <= pld_pkg::CW'(p1) - pld_pkg::CW'(p2);
    side2.degen <= degen1;
    apx2 <= pld_pkg::ProdW'(a1) * pld_pkg::ProdW'(px1);
    bpy2 <= pld_pkg::ProdW'(b1) * pld_pkg::ProdW'(py1);
    aa2 <= pld_pkg::SqW'(a1) * pld_pkg::SqW'(a1);
    bb2 <= pld_pkg::SqW'(b1) * pld_pkg::SqW'(b1);

    side3 <= side2;
    n3 <= num[pld_pkg::NumW-1] ? pld_pkg::NW'(-num) : pld_pkg::NW'(num);
    s3 <= ssum[pld_pkg::SW-1:0];

    side4 <= side3;
    s4 <= s3;
    hh4 <= pld_pkg::PpW'(n3[pld_pkg::NW-1:pld_pkg::NLo]) *
           pld_pkg::PpW'(n3[pld_pkg::NW-1:pld_pkg::NLo]);
    hl4 <= pld_pkg::PpW'(n3[pld_pkg::NW-1:pld_pkg::NLo]) *
           pld_pkg::PpW'(n3[pld_pkg::NLo-1:0]);
    ll4 <= pld_pkg::PpW'(n3[pld_pkg::NLo-1:0]) * pld_pkg::PpW'(n3[pld_pkg::NLo-1:0]);

    out_side <= side4;
    out_s <= s4;
    out_nn <= (pld_pkg::NNW'(hh4) << (2 * pld_pkg::NLo)) +
              (pld_pkg::NNW'(hl4) << (pld_pkg::NLo + 1)) + pld_pkg::NNW'(ll4);
  end

endmodule

FILE: hdl/pld_div.sv
module pld_div (
  input  logic clk,
  input  logic rst,
  input  logic in_v,
  input  pld_pkg::side_t in_side,
  input  logic [pld_pkg::NNW-1:0] in_nn,
  input  logic [pld_pkg::SW-1:0] in_s,
  output logic out_v,
  output pld_pkg::side_t out_side,
  output logic [pld_pkg::QW-1:0] out_q,
  output logic out_sat
);

  logic st_v [0:pld_pkg::QW];
  pld_pkg::side_t st_side [0:pld_pkg::QW];
  logic [pld_pkg::SW-1:0] st_rem [0:pld_pkg::QW];
  logic [pld_pkg::SW-1:0] st_s [0:pld_pkg::QW];
  // Dividend bits shift out at the top while quotient bits shift in below.
  logic [pld_pkg::QW-1:0] st_q [0:pld_pkg::QW];
  logic st_sat [0:pld_pkg::QW];
  logic [pld_pkg::SW-1:0] rem0;

  assign rem0 = pld_pkg::SW'(in_nn[pld_pkg::NNW-1:pld_pkg::QW]);

  always_ff @(posedge clk) begin
    if (rst) begin
      st_v[0] <= 1'b0;
    end else begin
      st_v[0] <= in_v;
    end
  end

  // A quotient that does not fit the register means the distance saturates.
  always_ff @(posedge clk) begin
    st_side[0] <= in_side;
    st_rem[0] <= rem0;
    st_s[0] <= in_s;
    st_q[0] <= in_nn[pld_pkg::QW-1:0];
    st_sat[0] <= rem0 >= in_s;
  end

  for (genvar k = 0; k < pld_pkg::QW; k++) begin : g_step
    logic [pld_pkg::SW:0] t;
    logic ge;
    logic [pld_pkg::SW:0] diff;

    assign t = {st_rem[k], st_q[k][pld_pkg::QW-1]};
    assign ge = t >= {1'b0, st_s[k]};
    assign diff = t - {1'b0, st_s[k]};

    always_ff @(posedge clk) begin
      if (rst) begin
        st_v[k+1] <= 1'b0;
      end else begin
        st_v[k+1] <= st_v[k];
      end
    end

    always_ff @(posedge clk) begin
      st_side[k+1] <= st_side[k];
      st_s[k+1] <= st_s[k];
      st_sat[k+1] <= st_sat[k];
      st_rem[k+1] <= ge ? diff[pld_pkg::SW-1:0] : t[pld_pkg::SW-1:0];
      st_q[k+1] <= {st_q[k][pld_pkg::QW-2:0], ge};
    end
  end

  assign out_v = st_v[pld_pkg::QW];
  assign out_side = st_side[pld_pkg::QW];
  assign out_q = st_q[pld_pkg::QW];
  assign out_sat = st_sat[pld_pkg::QW];

endmodule

FILE: hdl/pld_sqrt.sv
module pld_sqrt (
  input  logic clk,
  input  logic rst,
  input  logic in_v,
  input  pld_pkg::side_t in_side,
  input  logic [pld_pkg::QW-1:0] in_q,
  input  logic in_sat,
  output logic out_v,
  output pld_pkg::side_t out_side,
  output logic [pld_pkg::RootW-1:0] out_root,
  output logic out_sat
);

  logic st_v [0:pld_pkg::RootW];
  pld_pkg::side_t st_side [0:pld_pkg::RootW];
  logic [pld_pkg::QW-1:0] st_q [0:pld_pkg::RootW];
  logic [pld_pkg::RemW-1:0] st_rem [0:pld_pkg::RootW];
  logic [pld_pkg::RootW-1:0] st_root [0:pld_pkg::RootW];
  logic st_sat [0:pld_pkg::RootW];

  assign st_v[0] = in_v;
  assign st_side[0] = in_side;
  assign st_q[0] = in_q;
  assign st_rem[0] = '0;
  assign st_root[0] = '0;
  assign st_sat[0] = in_sat;

  // One root bit per stage: two radicand bits enter the remainder each time.
  for (genvar k = 0; k < pld_pkg::RootW; k++) begin : g_step
    logic [pld_pkg::RemW-1:0] t;
    logic [pld_pkg::RemW-1:0] trial;
    logic ge;

    assign t = {st_rem[k][pld_pkg::RemW-3:0], st_q[k][pld_pkg::QW-1:pld_pkg::QW-2]};
    assign trial = {1'b0, st_root[k], 2'b01};
    assign ge = t >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        st_v[k+1] <= 1'b0;
      end else begin
        st_v[k+1] <= st_v[k];
      end
    end

    always_ff @(posedge clk) begin
      st_side[k+1] <= st_side[k];
      st_sat[k+1] <= st_sat[k];
      st_q[k+1] <= {st_q[k][pld_pkg::QW-3:0], 2'b00};
      st_rem[k+1] <= ge ? t - trial : t;
      st_root[k+1] <= {st_root[k][pld_pkg::RootW-2:0], ge};
    end
  end

  assign out_v = st_v[pld_pkg::RootW];
  assign out_side = st_side[pld_pkg::RootW];
  assign out_root = st_root[pld_pkg::RootW];
  assign out_sat = st_sat[pld_pkg::RootW];

endmodule

FILE: hdl/point_line_distance_top.sv
// Point to line distance, fully pipelined.
// Drive the two line points and the probe point (signed Q8.8) with start high
// for one cycle; the word is taken at that edge. busy is always low, so a new
// word may be started in every cycle.
// Each word yields one result, shown on the result ports for exactly one cycle
// with done high, once the word has passed through every stage. Results leave in the
// order the words came in. The receiver cannot hold results off.
// line_a, line_b and line_c are the line coefficients; distance is
// |a*px+b*py+c| / sqrt(a*a+b*b) with 8 fraction bits, truncated, saturated at
// its all-ones value. degenerate flags coincident line points; distance is 0.
// Latency is set by the 36-stage restoring divider that forms n*n / s and the
// 18-stage square root that follows it, plus five arithmetic stages before
// them, the divider's input register and one output register.
// Synchronous reset clears all valid bits; words in flight are dropped.
module point_line_distance_top (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  logic signed [15:0] first_x,
  input  logic signed [15:0] first_y,
  input  logic signed [15:0] second_x,
  input  logic signed [15:0] second_y,
  input  logic signed [15:0] probe_x,
  input  logic signed [15:0] probe_y,
  output logic done,
  output logic signed [16:0] line_a,
  output logic signed [16:0] line_b,
  output logic signed [32:0] line_c,
  output logic [16:0] distance,
  output logic degenerate
);

  logic f_v, d_v, r_v, d_sat, r_sat;
  pld_pkg::side_t f_side, d_side, r_side;
  logic [pld_pkg::NNW-1:0] f_nn;
  logic [pld_pkg::SW-1:0] f_s;
  logic [pld_pkg::QW-1:0] d_q;
  logic [pld_pkg::RootW-1:0] r_root;
  logic [pld_pkg::DistW-1:0] dist_next;

  assign busy = 1'b0;

  pld_front u_front (
    .clk(clk), .rst(rst), .in_v(start),
    .x1(first_x), .y1(first_y), .x2(second_x), .y2(second_y),
    .px(probe_x), .py(probe_y),
    .out_v(f_v), .out_side(f_side), .out_nn(f_nn), .out_s(f_s)
  );

  pld_div u_div (
    .clk(clk), .rst(rst), .in_v(f_v), .in_side(f_side), .in_nn(f_nn), .in_s(f_s),
    .out_v(d_v), .out_side(d_side), .out_q(d_q), .out_sat(d_sat)
  );

  pld_sqrt u_sqrt (
    .clk(clk), .rst(rst), .in_v(d_v), .in_side(d_side), .in_q(d_q), .in_sat(d_sat),
    .out_v(r_v), .out_side(r_side), .out_root(r_root), .out_sat(r_sat)
  );

  always_comb begin
    if (r_side.degen) begin
      dist_next = '0;
    end else if (r_sat || r_root > pld_pkg::RootW'(pld_pkg::DistMax)) begin
      dist_next = pld_pkg::DistMax;
    end else begin
      dist_next = r_root[pld_pkg::DistW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= r_v;
    end
  end

  always_ff @(posedge clk) begin
    line_a <= r_side.a;
    line_b <= r_side.b;
    line_c <= r_side.c;
    distance <= dist_next;
    degenerate <= r_side.degen;
  end

endmodule

FILE: hdl/pld_checker.sv
module pld_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done,
  input logic signed [16:0] line_a,
  input logic signed [16:0] line_b,
  input logic signed [32:0] line_c,
  input logic [16:0] distance,
  input logic degenerate
);

  // Every accepted word comes out after the fixed pipeline latency.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##(pld_pkg::Latency) done)
    else $error("result missing after pipeline latency");

  // No result appears without a word taken at the matching time.
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, pld_pkg::Latency))
    else $error("result without matching input word");

  a_degen_dist: assert property (@(posedge clk) disable iff (rst)
    (done && degenerate) |-> (distance == '0))
    else $error("degenerate line with nonzero distance");

  a_degen_coef: assert property (@(posedge clk) disable iff (rst)
    (done && degenerate) |-> (line_a == '0 && line_b == '0 && line_c == '0))
    else $error("degenerate line with nonzero coefficients");

endmodule

bind point_line_distance_top pld_checker u_pld_checker (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done),
  .line_a(line_a), .line_b(line_b), .line_c(line_c),
  .distance(distance), .degenerate(degenerate)
);
